// ===== hdl/bba_pkg.sv =====
// shared types, codes and defaults for the buddy block allocator
// no dependencies; used by every module of the block
package bba_pkg;

	localparam int POOL_PAGES_DEF = 16;
	localparam int NUM_LEVELS_DEF = 8;
	localparam int MIN_SHIFT_DEF  = 5;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int ADDR_W = 16;
	localparam int REQ_W  = 16;
	localparam int HDR_W  = 7;
	localparam int STAT_W = 3;
	localparam int SHW    = 5;
	localparam int MAP_W  = 32;
	localparam int MAP_WB = 5;

	localparam logic [HDR_W-1:0] HEADER_RESET = 7'd24;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NO_MEM    = 3'd1,
		STAT_TOO_LARGE = 3'd2,
		STAT_ZERO      = 3'd3,
		STAT_BAD_FREE  = 3'd4
	} stat_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		MS_SRCH  = 2'd0,
		MS_SELF  = 2'd1,
		MS_BUDDY = 2'd2,
		MS_SIB   = 2'd3
	} map_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_TAG_EVAL,
		S_SRCH_RD,
		S_SRCH_EVAL,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_TAG_WR,
		S_MERGE_RD,
		S_MERGE_EVAL,
		S_FINAL_WR,
		S_RESULT
	} fsm_t;

	typedef struct packed {
		logic     clr_step;
		logic     take_in;
		logic     map_rd;
		logic     map_wr;
		logic     map_set;
		map_sel_t map_sel;
		logic     tag_rd;
		logic     tag_wr;
		logic     tag_clr;
		logic     srch_init;
		logic     srch_next;
		logic     found_load;
		logic     lvl_dec;
		logic     free_load;
		logic     merge_step;
		logic     stat_load;
		stat_t    stat_code;
		logic     res_load;
	} bba_cmd_t;

	typedef struct packed {
		logic  clr_last;
		func_t func;
		logic  req_zero;
		logic  too_large;
		logic  misalign;
		logic  slot_oob;
		logic  tag_bad;
		logic  map_any;
		logic  buddy_bit;
		logic  row_last;
		logic  lvl_last;
		logic  at_want;
		logic  out_busy;
	} bba_stat_t;

endpackage

// ===== hdl/bba_ctrl.sv =====
// controller state machine of the buddy block allocator
// depends on bba_pkg; drives bba_dp through command and status structs
module bba_ctrl
	import bba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  bba_stat_t st,
	output bba_cmd_t  cmd
);

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.func == FN_ALLOC) begin
					if (st.req_zero) begin
						cmd.stat_load = 1'b1;
						cmd.stat_code = STAT_ZERO;
						state_d       = S_RESULT;
					end else if (st.too_large) begin
						cmd.stat_load = 1'b1;
						cmd.stat_code = STAT_TOO_LARGE;
						state_d       = S_RESULT;
					end else begin
						cmd.srch_init = 1'b1;
						state_d       = S_SRCH_RD;
					end
				end else begin
					if (st.misalign || st.slot_oob) begin
						cmd.stat_load = 1'b1;
						cmd.stat_code = STAT_BAD_FREE;
						state_d       = S_RESULT;
					end else begin
						cmd.tag_rd = 1'b1;
						state_d    = S_TAG_EVAL;
					end
				end
			end
			S_TAG_EVAL: begin
				if (st.tag_bad) begin
					cmd.stat_load = 1'b1;
					cmd.stat_code = STAT_BAD_FREE;
					state_d       = S_RESULT;
				end else begin
					cmd.free_load = 1'b1;
					cmd.tag_wr    = 1'b1;
					cmd.tag_clr   = 1'b1;
					state_d       = S_MERGE_RD;
				end
			end
			S_MERGE_RD: begin
				cmd.map_rd = 1'b1;
				if (st.lvl_last) begin
					cmd.map_sel = MS_SELF;
					state_d     = S_FINAL_WR;
				end else begin
					cmd.map_sel = MS_BUDDY;
					state_d     = S_MERGE_EVAL;
				end
			end
			S_MERGE_EVAL: begin
				if (st.buddy_bit) begin
					cmd.map_wr     = 1'b1;
					cmd.map_sel    = MS_BUDDY;
					cmd.merge_step = 1'b1;
					state_d        = S_MERGE_RD;
				end else begin
					cmd.map_rd  = 1'b1;
					cmd.map_sel = MS_SELF;
					state_d     = S_FINAL_WR;
				end
			end
			S_FINAL_WR: begin
				cmd.map_wr    = 1'b1;
				cmd.map_set   = 1'b1;
				cmd.map_sel   = MS_SELF;
				cmd.stat_load = 1'b1;
				cmd.stat_code = STAT_OK;
				state_d       = S_RESULT;
			end
			S_SRCH_RD: begin
				cmd.map_rd  = 1'b1;
				cmd.map_sel = MS_SRCH;
				state_d     = S_SRCH_EVAL;
			end
			S_SRCH_EVAL: begin
				cmd.map_sel = MS_SRCH;
				if (st.map_any) begin
					cmd.map_wr     = 1'b1;
					cmd.found_load = 1'b1;
					state_d        = st.at_want ? S_TAG_WR : S_SPLIT_RD;
				end else if (st.row_last && st.lvl_last) begin
					cmd.stat_load = 1'b1;
					cmd.stat_code = STAT_NO_MEM;
					state_d       = S_RESULT;
				end else begin
					cmd.srch_next = 1'b1;
					state_d       = S_SRCH_RD;
				end
			end
			S_SPLIT_RD: begin
				cmd.map_rd  = 1'b1;
				cmd.map_sel = MS_SIB;
				state_d     = S_SPLIT_WR;
			end
			S_SPLIT_WR: begin
				cmd.map_wr  = 1'b1;
				cmd.map_set = 1'b1;
				cmd.map_sel = MS_SIB;
				if (st.at_want) begin
					state_d = S_TAG_WR;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d     = S_SPLIT_RD;
				end
			end
			S_TAG_WR: begin
				cmd.tag_wr    = 1'b1;
				cmd.stat_load = 1'b1;
				cmd.stat_code = STAT_OK;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				if (!st.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== hdl/bba_dp.sv =====
// datapath of the buddy block allocator: free map and tag memories,
// address and level registers, header register and result register; depends on bba_pkg
module bba_dp
	import bba_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int MIN_SHIFT  = MIN_SHIFT_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int LW         = $clog2(NUM_LEVELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [HDR_W-1:0]  cfg_wr_data,
	input  logic              in_func,
	input  logic [REQ_W-1:0]  in_req,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [STAT_W-1:0] out_status,
	output logic [ADDR_W-1:0] out_addr,
	output logic [LW-1:0]     out_level,
	input  bba_cmd_t          cmd,
	output bba_stat_t         st
);

	localparam int TOP   = NUM_LEVELS - 1;
	localparam int SLOTS = POOL_PAGES << TOP;

	function automatic int rows_of(int k);
		return ((SLOTS >> k) + MAP_W - 1) / MAP_W;
	endfunction

	function automatic int row_base(int k);
		int acc;
		acc = 0;
		for (int j = 0; j < k; j++) begin
			acc = acc + rows_of(j);
		end
		return acc;
	endfunction

	localparam int ROWS_TOTAL = row_base(NUM_LEVELS);
	localparam int TOP_BASE   = row_base(TOP);
	localparam int RW         = (ROWS_TOTAL > 1) ? $clog2(ROWS_TOTAL) : 1;
	localparam int TAW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CLR_N      = (ROWS_TOTAL > SLOTS) ? ROWS_TOTAL : SLOTS;
	localparam int CW         = $clog2(CLR_N + 1);
	localparam int TW         = $clog2(NUM_LEVELS + 1);
	localparam int TOT_W      = REQ_W + 1;

	logic [RW-1:0] row_base_c [NUM_LEVELS];
	logic [RW-1:0] row_last_c [NUM_LEVELS];

	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_rows
		assign row_base_c[g] = RW'(row_base(g));
		assign row_last_c[g] = RW'(rows_of(g) - 1);
	end

	logic [MAP_W-1:0] map_mem [ROWS_TOTAL];
	logic [TW-1:0]    tag_mem [SLOTS];

	logic [HDR_W-1:0]  header_q;
	func_t             func_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LW-1:0]     lvl_q;
	logic [LW-1:0]     want_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     clr_q;
	logic [MAP_W-1:0]  map_rd_q;
	logic [TW-1:0]     tag_rd_q;
	stat_t             stat_q;
	logic              m_tvalid_q;

	logic [TOT_W-1:0]  total;
	logic [LW-1:0]     want_c;
	logic [SHW-1:0]    sh_amt;
	logic [ADDR_W-1:0] self_idx;
	logic [ADDR_W-1:0] bit_idx;
	logic [RW-1:0]     map_addr;
	logic [MAP_WB-1:0] map_pos;
	logic [MAP_WB-1:0] found_pos;
	logic [MAP_WB-1:0] buddy_pos;
	logic [31:0]       found_wide;
	logic [ADDR_W-1:0] found_addr;
	logic [ADDR_W-1:0] size_c;
	logic [MAP_W-1:0]  map_wdata;
	logic [MAP_W-1:0]  clr_row;
	logic [31:0]       clr_rel;
	logic [TAW-1:0]    tag_addr;
	logic              wr_en;
	logic [RW-1:0]     wr_addr;
	logic [MAP_W-1:0]  wr_data;

	assign total  = {1'b0, req_q} + TOT_W'(header_q);
	assign sh_amt = SHW'(MIN_SHIFT) + SHW'(lvl_q);

	always_comb begin
		want_c = LW'(TOP);
		for (int l = TOP - 1; l >= 0; l--) begin
			if (32'(total) <= (32'd1 << (MIN_SHIFT + l))) begin
				want_c = LW'(l);
			end
		end
	end

	assign self_idx = addr_q >> sh_amt;

	always_comb begin
		case (cmd.map_sel)
			MS_BUDDY: bit_idx = self_idx ^ ADDR_W'(1);
			MS_SIB:   bit_idx = self_idx | ADDR_W'(1);
			default:  bit_idx = self_idx;
		endcase
	end

	always_comb begin
		found_pos = '0;
		for (int b = MAP_W - 1; b >= 0; b--) begin
			if (map_rd_q[b]) begin
				found_pos = MAP_WB'(b);
			end
		end
	end

	always_comb begin
		if (cmd.map_sel == MS_SRCH) begin
			map_addr = row_base_c[lvl_q] + row_q;
			map_pos  = found_pos;
		end else begin
			map_addr = row_base_c[lvl_q] + RW'(bit_idx >> MAP_WB);
			map_pos  = bit_idx[MAP_WB-1:0];
		end
	end

	assign buddy_pos  = self_idx[MAP_WB-1:0] ^ MAP_WB'(1);
	assign found_wide = (32'({row_q, found_pos})) << sh_amt;
	assign found_addr = found_wide[ADDR_W-1:0];
	assign size_c     = ADDR_W'(1) << sh_amt;
	assign tag_addr   = TAW'(addr_q >> MIN_SHIFT);

	always_comb begin
		map_wdata = map_rd_q;
		map_wdata[map_pos] = cmd.map_set;
	end

	// reset contents: only whole-page bits below the pool size are free
	assign clr_rel = 32'(clr_q) - 32'(TOP_BASE);
	always_comb begin
		for (int b = 0; b < MAP_W; b++) begin
			clr_row[b] = (32'(clr_q) >= 32'(TOP_BASE)) &&
				(((clr_rel << MAP_WB) | 32'(b)) < 32'(POOL_PAGES));
		end
	end

	always_comb begin
		if (cmd.clr_step) begin
			wr_en   = 32'(clr_q) < 32'(ROWS_TOTAL);
			wr_addr = clr_q[RW-1:0];
			wr_data = clr_row;
		end else begin
			wr_en   = cmd.map_wr;
			wr_addr = map_addr;
			wr_data = map_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (cmd.map_rd) begin
			map_rd_q <= map_mem[map_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			if (32'(clr_q) < 32'(SLOTS)) begin
				tag_mem[clr_q[TAW-1:0]] <= '0;
			end
		end else if (cmd.tag_wr) begin
			tag_mem[tag_addr] <= cmd.tag_clr ? '0 : TW'(want_q) + TW'(1);
		end
		if (cmd.tag_rd) begin
			tag_rd_q <= tag_mem[tag_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RESET;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				header_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd.res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			func_q <= func_t'(in_func);
			req_q  <= in_req;
			addr_q <= in_addr;
		end
		if (cmd.srch_init) begin
			lvl_q  <= want_c;
			want_q <= want_c;
			row_q  <= '0;
		end
		if (cmd.srch_next) begin
			if (row_q == row_last_c[lvl_q]) begin
				lvl_q <= lvl_q + LW'(1);
				row_q <= '0;
			end else begin
				row_q <= row_q + RW'(1);
			end
		end
		if (cmd.found_load) begin
			addr_q <= found_addr;
			if (lvl_q != want_q) begin
				lvl_q <= lvl_q - LW'(1);
			end
		end
		if (cmd.lvl_dec) begin
			lvl_q <= lvl_q - LW'(1);
		end
		if (cmd.free_load) begin
			lvl_q <= LW'(tag_rd_q - TW'(1));
		end
		if (cmd.merge_step) begin
			addr_q <= addr_q & ~size_c;
			lvl_q  <= lvl_q + LW'(1);
		end
		if (cmd.stat_load) begin
			stat_q <= cmd.stat_code;
		end
		if (cmd.res_load) begin
			out_status <= stat_q;
			out_addr   <= (stat_q == STAT_OK) ? addr_q : '0;
			out_level  <= (stat_q == STAT_OK) ? lvl_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		st.clr_last  = clr_q == CW'(CLR_N - 1);
		st.func      = func_q;
		st.req_zero  = req_q == '0;
		st.too_large = 32'(total) > 32'(PAGE_BYTES);
		st.misalign  = addr_q[MIN_SHIFT-1:0] != '0;
		st.slot_oob  = 32'(addr_q >> MIN_SHIFT) >= 32'(SLOTS);
		st.tag_bad   = (tag_rd_q == '0) || (tag_rd_q > TW'(NUM_LEVELS));
		st.map_any   = map_rd_q != '0;
		st.buddy_bit = map_rd_q[buddy_pos];
		st.row_last  = row_q == row_last_c[lvl_q];
		st.lvl_last  = lvl_q == LW'(TOP);
		st.at_want   = lvl_q == want_q;
		st.out_busy  = m_tvalid_q && !m_tready;
	end

endmodule

// ===== hdl/buddy_block_allocator.sv =====
// buddy allocator over a fixed page pool; one transaction in flight at a time
// a new request is taken only after the previous result is loaded into the output
// register; that load waits while an earlier result is held back by m_tready
// after arst_n a clearing pass over the free map and tag memories runs before
// the first transaction is taken; the header register resets to 24
module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int MIN_SHIFT  = MIN_SHIFT_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int LW         = $clog2(NUM_LEVELS),
	parameter int OUT_W      = ((ADDR_W + LW + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [HDR_W-1:0]  cfg_wr_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // request_bytes, block_address
	input  logic              s_tuser,   // func
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // result_address, result_level, zero fill
	output logic [STAT_W-1:0] m_tuser    // status
);

	bba_cmd_t          cmd;
	bba_stat_t         st;
	logic [ADDR_W-1:0] out_addr;
	logic [LW-1:0]     out_level;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	bba_dp #(
		.POOL_PAGES (POOL_PAGES),
		.NUM_LEVELS (NUM_LEVELS),
		.MIN_SHIFT  (MIN_SHIFT),
		.PAGE_BYTES (PAGE_BYTES),
		.LW         (LW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_func     (s_tuser),
		.in_req      (s_tdata[15:0]),
		.in_addr     (s_tdata[31:16]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_status  (m_tuser),
		.out_addr    (out_addr),
		.out_level   (out_level),
		.cmd         (cmd),
		.st          (st)
	);

	assign m_tdata = OUT_W'({out_level, out_addr});

endmodule

// ===== hdl/bba_checker.sv =====
// port-level checks for the buddy block allocator, bound to the top level
// depends on bba_pkg
module bba_checker
	import bba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [31:0]       s_tdata,
	input logic              s_tuser,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [23:0]       m_tdata,
	input logic [STAT_W-1:0] m_tuser
);

	logic [ADDR_W-1:0] blk_mask;

	assign blk_mask = (ADDR_W'(1) << (MIN_SHIFT_DEF + 32'(m_tdata[18:16]))) - ADDR_W'(1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("error result carries nonzero address or level");

	a_ok_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK |-> (m_tdata[15:0] & blk_mask) == '0)
		else $error("granted block not aligned to its level");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while one is in flight");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/buddy_block_allocator_tb.sv =====
// self-checking testbench for buddy_block_allocator: stream driver, monitor and allocator predictor
// depends on bba_pkg and the buddy_block_allocator rtl
module buddy_block_allocator_tb;
	import bba_pkg::*;

	localparam int PAGES = 16;
	localparam int LEVELS = 8;
	localparam int TOP = LEVELS - 1;
	localparam int SLOT_CNT = PAGES << TOP;
	localparam int MAP_CNT = PAGES * ((1 << LEVELS) - 1);

	typedef struct packed {
		func_t       func;
		logic [15:0] req;
		logic [15:0] addr;
	} op_t;

	typedef struct packed {
		stat_t       st;
		logic [15:0] addr;
		logic [2:0]  lvl;
	} grant_t;

	logic clk, arst_n, cfg_wr_en;
	logic [HDR_W-1:0] cfg_wr_data;
	logic s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
	logic [31:0] s_tdata;
	logic [23:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic s_acc;

	buddy_block_allocator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	bit free_bits[MAP_CNT];
	bit [3:0] tags[SLOT_CNT];
	int unsigned hdr;
	op_t pending_ops[$];
	grant_t expected_grants[$];
	int errors, n_sent, n_seen, n_ok;
	bit drv_hold;
	logic [15:0] live_blocks[$];
	logic [15:0] live_shadow[$];

	function automatic int unsigned lvl_base(int unsigned l);
		int unsigned b;
		b = 0;
		for (int i = 0; i < l; i++) b += SLOT_CNT >> i;
		return b;
	endfunction

	function automatic int unsigned map_at(int unsigned l, int unsigned a);
		return lvl_base(l) + (a >> (5 + l));
	endfunction

	function automatic grant_t predict_grant(op_t o);
		grant_t g;
		int unsigned tot, sz, want, k, a, lv, base;
		bit hit;
		g = '{STAT_OK, 16'd0, 3'd0};
		if (o.func == FN_ALLOC) begin
			tot = o.req + hdr;
			if (o.req == 0) g.st = STAT_ZERO;
			else if (tot > 4096) g.st = STAT_TOO_LARGE;
			else begin
				want = 0; sz = 32; hit = 0; a = 0;
				while (tot > sz && want < TOP) begin
					sz <<= 1; want++;
				end
				for (k = want; k < LEVELS && !hit; k++) begin
					base = lvl_base(k);
					for (int i = 0; i < (SLOT_CNT >> k); i++)
						if (free_bits[base + i]) begin
							free_bits[base + i] = 0; a = i << (5 + k); hit = 1; break;
						end
					if (hit) break;
				end
				if (!hit) g.st = STAT_NO_MEM;
				else begin
					for (int j = k; j > want; j--)
						free_bits[map_at(j - 1, a | (1 << (4 + j)))] = 1;
					tags[a >> 5] = 4'(want + 1);
					g.addr = 16'(a); g.lvl = 3'(want);
					live_blocks.push_back(16'(a));
				end
			end
		end else begin
			a = o.addr;
			if (a[4:0] != 0 || (a >> 5) >= SLOT_CNT || tags[a >> 5] == 0 || tags[a >> 5] > LEVELS)
				g.st = STAT_BAD_FREE;
			else begin
				lv = tags[a >> 5] - 1;
				tags[a >> 5] = 0;
				while (lv < TOP) begin
					sz = 1 << (5 + lv);
					if (!free_bits[map_at(lv, a ^ sz)]) break;
					free_bits[map_at(lv, a ^ sz)] = 0;
					a &= ~sz; lv++;
				end
				free_bits[map_at(lv, a)] = 1;
				g.addr = 16'(a); g.lvl = 3'(lv);
			end
		end
		return g;
	endfunction

	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	int unsigned s_gap;
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_acc)) begin
			if (!drv_hold && s_gap == 0 && pending_ops.size() > 0) begin
				op_t o;
				o = pending_ops.pop_front();
				s_tvalid <= 1;
				s_tuser <= o.func;
				s_tdata <= {o.addr, o.req};
				s_gap = pick_gap();
			end else begin
				s_tvalid <= 0;
				if (s_gap > 0) s_gap--;
			end
		end
	end

	// prediction at acceptance
	always @(posedge clk) begin
		s_acc <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			op_t o;
			o.func = func_t'(s_tuser);
			o.req = s_tdata[15:0];
			o.addr = s_tdata[31:16];
			expected_grants.push_back(predict_grant(o));
			n_sent++;
		end
	end

	// monitor
	int unsigned m_gap;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			grant_t e;
			n_seen++;
			if (expected_grants.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				e = expected_grants.pop_front();
				if (e.st == STAT_OK) n_ok++;
				if (m_tuser != e.st) report_mismatch("status", m_tuser, e.st);
				if (m_tdata[15:0] != e.addr) report_mismatch("address", m_tdata[15:0], e.addr);
				if (m_tdata[18:16] != e.lvl) report_mismatch("level", m_tdata[18:16], e.lvl);
				if (m_tdata[23:19] != 0) report_mismatch("fill", m_tdata[23:19], 0);
			end
		end
	end

	always @(negedge clk) begin
		if (m_gap > 0) begin
			m_gap--;
			m_tready <= 0;
		end else begin
			m_tready <= 1;
			if ($urandom_range(0, 3) == 0) m_gap = pick_gap();
		end
	end

	function automatic op_t mk_alloc(int unsigned r);
		return '{FN_ALLOC, r[15:0], 16'($urandom)};
	endfunction

	function automatic op_t mk_free(int unsigned a);
		return '{FN_FREE, 16'($urandom), a[15:0]};
	endfunction

	task automatic drain();
		while (pending_ops.size() > 0 || s_tvalid || expected_grants.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_header(int unsigned v);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v[HDR_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 0;
		hdr = v & 7'h7f;
	endtask

	function automatic int unsigned rand_size();
		case ($urandom_range(0, 9))
			0: return $urandom_range(2000, 4096);
			1: return $urandom_range(0, 65535);
			2, 3: return $urandom_range(300, 1200);
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	task automatic sync_live();
		while (live_blocks.size() > 0) live_shadow.push_back(live_blocks.pop_front());
	endtask

	task automatic random_phase(int n);
		int idx;
		logic [15:0] a;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				pending_ops.push_back(mk_free($urandom_range(0, 65535)));
			else if (live_shadow.size() > 0 && $urandom_range(0, 99) < 45) begin
				idx = $urandom_range(0, live_shadow.size() - 1);
				a = live_shadow[idx];
				live_shadow.delete(idx);
				pending_ops.push_back(mk_free(a));
			end else
				pending_ops.push_back(mk_alloc(rand_size()));
			if (pending_ops.size() > 4) begin
				while (pending_ops.size() > 1) @(posedge clk);
				sync_live();
			end
		end
	endtask

	initial begin
		foreach (free_bits[i]) free_bits[i] = 0;
		foreach (tags[i]) tags[i] = 0;
		for (int p = 0; p < PAGES; p++) free_bits[lvl_base(TOP) + p] = 1;
		hdr = 24;
		errors = 0; n_sent = 0; n_seen = 0; n_ok = 0;
		drv_hold = 0; s_gap = 0; m_gap = 0; s_acc = 0;
		arst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1;

		write_header(0);
		pending_ops.push_back(mk_alloc(0));
		pending_ops.push_back(mk_alloc(1));
		pending_ops.push_back(mk_alloc(32));
		pending_ops.push_back(mk_alloc(33));
		pending_ops.push_back(mk_alloc(4096));
		pending_ops.push_back(mk_alloc(4097));
		pending_ops.push_back(mk_alloc(65535));
		pending_ops.push_back(mk_free(0));
		pending_ops.push_back(mk_free(0));
		pending_ops.push_back(mk_free(32));
		pending_ops.push_back(mk_free(4096));
		pending_ops.push_back(mk_free(3));
		pending_ops.push_back(mk_free(65535));
		pending_ops.push_back(mk_free(65504));
		pending_ops.push_back(mk_free(64));
		drain();
		live_blocks.delete();
		// exhaust the pool with whole pages, then release them
		write_header(64);
		for (int i = 0; i < 17; i++) pending_ops.push_back(mk_alloc(4032));
		pending_ops.push_back(mk_alloc(4033));
		drain();
		live_blocks.delete();
		for (int i = 0; i < 16; i++) pending_ops.push_back(mk_free(i * 4096));
		drain();

		write_header(24);
		random_phase(180);
		// pressure: hold the sender until every result is back
		drv_hold = 1;
		while (expected_grants.size() > 0 || s_tvalid) @(posedge clk);
		drv_hold = 0;
		random_phase(120);
		drain();
		sync_live();
		write_header(127);
		random_phase(110);
		drain();
		sync_live();
		write_header($urandom_range(0, 64));
		random_phase(110);
		drain();

		$display("covered %0d transactions in, %0d results out, %0d granted or freed ok",
			n_sent, n_seen, n_ok);
		$display("header settings 0, 24, 64, 127 and a random one; directed edge cases first");
		if (errors == 0 && expected_grants.size() == 0)
			$display("[ OK ] regression clean");
		else begin
			if (expected_grants.size() != 0)
				$display("%0d results never arrived", expected_grants.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d results outstanding", expected_grants.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
